>>> hdl/battery_level_gauge_macros.svh
// Assertion helpers for the battery level gauge checker.
// Both sample on i_clk and stay quiet while i_rst_n is low.
`ifndef BATTERY_LEVEL_GAUGE_MACROS_SVH
`define BATTERY_LEVEL_GAUGE_MACROS_SVH

// Same-cycle implication.
`define BLG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("battery level gauge check failed");

// Next-cycle implication.
`define BLG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("battery level gauge check failed");

`endif

>>> hdl/blg_pkg.sv
package blg_pkg;

    localparam int DEF_GAIN_FRAC_BITS = 12;
    localparam int DEF_AVG_FRAC_BITS  = 8;

    localparam int ADC_W        = 12;
    localparam int GAIN_W       = 16;
    localparam int SMOOTH_W     = 9;
    localparam int MIN_W        = 12;
    localparam int MAX_W        = 13;
    localparam int HYST_W       = 7;
    localparam int USB_W        = 15;
    localparam int MV_W         = 16;
    localparam int PCT_W        = 7;
    localparam int BARS_W       = 2;
    localparam int SLOPE_W      = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int PROD_SCALE_W = ADC_W + GAIN_W;
    localparam int DIV_CNT_W    = $clog2(PCT_W);

    localparam int ALPHA_ONE   = 256;
    localparam int ALPHA_SHIFT = 8;

    localparam logic [GAIN_W-1:0]   RST_BATTERY_GAIN = GAIN_W'(8192);
    localparam logic [GAIN_W-1:0]   RST_VBUS_GAIN    = GAIN_W'(8192);
    localparam logic [SMOOTH_W-1:0] RST_SMOOTHING    = SMOOTH_W'(26);
    localparam logic [MIN_W-1:0]    RST_MIN_MV       = MIN_W'(3000);
    localparam logic [MAX_W-1:0]    RST_MAX_MV       = MAX_W'(4200);
    localparam logic [HYST_W-1:0]   RST_HYST         = HYST_W'(2);
    localparam logic [USB_W-1:0]    RST_USB_MV       = USB_W'(4000);

    // Knees of the discharge curve
    localparam int KNEE_FULL_MV     = 4000;
    localparam int KNEE_MID_MV      = 3700;
    localparam int KNEE_LOW_MV      = 3500;
    localparam int SEG_MID_SPAN_MV  = 300;
    localparam int SEG_LOW_SPAN_MV  = 200;
    localparam int PCT_KNEE_FULL    = 80;
    localparam int PCT_KNEE_MID     = 30;
    localparam int PCT_KNEE_LOW     = 10;
    localparam int PCT_MAX          = 100;
    localparam int SLOPE_TOP        = 20;
    localparam int SLOPE_MID        = 50;
    localparam int SLOPE_LOW        = 20;
    localparam int SLOPE_BOTTOM     = 10;
    localparam int BARS_THREE_PCT   = 67;
    localparam int BARS_TWO_PCT     = 34;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BATTERY_GAIN  = 3'd0,
        CFG_VBUS_GAIN     = 3'd1,
        CFG_SMOOTHING     = 3'd2,
        CFG_MIN_MV        = 3'd3,
        CFG_MAX_MV        = 3'd4,
        CFG_PERCENT_HYST  = 3'd5,
        CFG_USB_THRESHOLD = 3'd6
    } t_cfg_reg;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MUL_BAT_GAIN,
        OP_MUL_VBUS_GAIN,
        OP_SAT_VBUS,
        OP_FIRST,
        OP_MUL_BAT_OLD,
        OP_MUL_BAT_NEW,
        OP_MUL_VBUS_OLD,
        OP_MUL_VBUS_NEW,
        OP_BLEND_VBUS,
        OP_CURVE,
        OP_DIV_STEP,
        OP_COMMIT
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_BG,
        ST_MUL_VG,
        ST_SAT_V,
        ST_FIRST,
        ST_MUL_BO,
        ST_MUL_BN,
        ST_MUL_VO,
        ST_MUL_VN,
        ST_BLEND_V,
        ST_CURVE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_dp_op op;
        logic   in_take;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
    } t_dp_status;

endpackage

>>> hdl/blg_ctrl.sv
module blg_ctrl
    import blg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PCT_W - 1);

    t_state                 r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;
    logic                   r_out_valid, n_out_valid;
    logic                   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_div_cnt      = r_div_cnt;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_in_ready     = 1'b0;
        o_cmd.op       = OP_IDLE;
        o_cmd.in_take  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op      = OP_LOAD;
                    o_cmd.in_take = 1'b1;
                    n_state       = ST_MUL_BG;
                end
            end
            ST_MUL_BG: begin
                o_cmd.op = OP_MUL_BAT_GAIN;
                n_state  = ST_MUL_VG;
            end
            ST_MUL_VG: begin
                o_cmd.op = OP_MUL_VBUS_GAIN;
                n_state  = ST_SAT_V;
            end
            ST_SAT_V: begin
                o_cmd.op = OP_SAT_VBUS;
                n_state  = i_status.first ? ST_FIRST : ST_MUL_BO;
            end
            ST_FIRST: begin
                o_cmd.op = OP_FIRST;
                n_state  = ST_CURVE;
            end
            ST_MUL_BO: begin
                o_cmd.op = OP_MUL_BAT_OLD;
                n_state  = ST_MUL_BN;
            end
            ST_MUL_BN: begin
                o_cmd.op = OP_MUL_BAT_NEW;
                n_state  = ST_MUL_VO;
            end
            ST_MUL_VO: begin
                o_cmd.op = OP_MUL_VBUS_OLD;
                n_state  = ST_MUL_VN;
            end
            ST_MUL_VN: begin
                o_cmd.op = OP_MUL_VBUS_NEW;
                n_state  = ST_BLEND_V;
            end
            ST_BLEND_V: begin
                o_cmd.op = OP_BLEND_VBUS;
                n_state  = ST_CURVE;
            end
            ST_CURVE: begin
                o_cmd.op  = OP_CURVE;
                n_div_cnt = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                // hold the finished item until the output register is free
                if (out_free) begin
                    o_cmd.op    = OP_COMMIT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/blg_dp.sv
module blg_dp
    import blg_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
    parameter int AVG_FRAC_BITS  = DEF_AVG_FRAC_BITS
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [ADC_W-1:0]      i_battery_mv,
    input  logic [ADC_W-1:0]      i_vbus_mv,
    input  logic                  i_switch_closed,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic [MV_W-1:0]       o_voltage_mv,
    output logic [PCT_W-1:0]      o_percent,
    output logic                  o_usb_present,
    output logic                  o_charging,
    output logic                  o_disconnected,
    output logic [BARS_W-1:0]     o_bars
);

    localparam int AVG_W  = MV_W + AVG_FRAC_BITS;
    localparam int PROD_W = AVG_W + GAIN_W;
    localparam int SH_L   = (AVG_FRAC_BITS > GAIN_FRAC_BITS) ?
                            (AVG_FRAC_BITS - GAIN_FRAC_BITS) : 0;
    localparam int SH_R   = (GAIN_FRAC_BITS > AVG_FRAC_BITS) ?
                            (GAIN_FRAC_BITS - AVG_FRAC_BITS) : 0;
    localparam int WIDE_W = PROD_SCALE_W + SH_L;
    localparam int NUM_W  = AVG_W + SLOPE_W;
    localparam int DIV_W  = AVG_W + PCT_W - 1;

    localparam logic [AVG_W-1:0] V_KNEE_FULL = AVG_W'(KNEE_FULL_MV) << AVG_FRAC_BITS;
    localparam logic [AVG_W-1:0] V_KNEE_MID  = AVG_W'(KNEE_MID_MV) << AVG_FRAC_BITS;
    localparam logic [AVG_W-1:0] V_KNEE_LOW  = AVG_W'(KNEE_LOW_MV) << AVG_FRAC_BITS;
    localparam logic [AVG_W-1:0] V_SPAN_MID  = AVG_W'(SEG_MID_SPAN_MV) << AVG_FRAC_BITS;
    localparam logic [AVG_W-1:0] V_SPAN_LOW  = AVG_W'(SEG_LOW_SPAN_MV) << AVG_FRAC_BITS;
    localparam logic [SMOOTH_W-1:0] ALPHA_FULL = SMOOTH_W'(ALPHA_ONE);
    localparam logic [PCT_W-1:0]    PCT_TOP    = PCT_W'(PCT_MAX);

    // Scale a reading product to the average format and clip at its top.
    function automatic logic [AVG_W-1:0] sat_scale(input logic [PROD_SCALE_W-1:0] p);
        logic [WIDE_W-1:0] w;
        w = (WIDE_W'(p) << SH_L) >> SH_R;
        if ((w >> AVG_W) != '0) begin
            return {AVG_W{1'b1}};
        end
        return w[AVG_W-1:0];
    endfunction

    // Configuration registers
    logic [GAIN_W-1:0]   r_battery_gain;
    logic [GAIN_W-1:0]   r_vbus_gain;
    logic [SMOOTH_W-1:0] r_smoothing;
    logic [MIN_W-1:0]    r_min_mv;
    logic [MAX_W-1:0]    r_max_mv;
    logic [HYST_W-1:0]   r_hyst;
    logic [USB_W-1:0]    r_usb_mv;

    // Running state
    logic              r_seen;
    logic [PCT_W-1:0]  r_shown;
    logic [AVG_W-1:0]  r_bat_avg;
    logic [AVG_W-1:0]  r_vbus_avg;

    // Working registers
    logic [ADC_W-1:0]  r_bat_in;
    logic [ADC_W-1:0]  r_vbus_in;
    logic              r_sw;
    logic              r_first;
    logic [AVG_W-1:0]  r_bx;
    logic [AVG_W-1:0]  r_vx;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_acc;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [PCT_W-1:0]  r_quo;
    logic [PCT_W-1:0]  r_base;
    logic              r_is_zero;
    logic              r_is_full;

    // Output registers
    logic [MV_W-1:0]   r_voltage_mv;
    logic [PCT_W-1:0]  r_percent;
    logic              r_usb_present;
    logic              r_charging;
    logic              r_disconnected;
    logic [BARS_W-1:0] r_bars;

    logic [SMOOTH_W-1:0] alpha;
    logic [SMOOTH_W-1:0] alpha_inv;
    logic [AVG_W-1:0]    mul_a;
    logic [GAIN_W-1:0]   mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [PROD_W:0]     blend_sum;
    logic [AVG_W-1:0]    blend_res;
    logic [AVG_W-1:0]    v_lo;
    logic [AVG_W-1:0]    v_hi;
    logic [AVG_W-1:0]    v_usb;
    logic [AVG_W-1:0]    c_diff;
    logic [AVG_W-1:0]    c_den;
    logic [SLOPE_W-1:0]  c_slope;
    logic [PCT_W-1:0]    c_base;
    logic [NUM_W-1:0]    c_num;
    logic                div_take;
    logic [PCT_W:0]      pct_sum;
    logic [PCT_W-1:0]    pct;
    logic [PCT_W-1:0]    pct_diff;
    logic [PCT_W-1:0]    new_shown;
    logic [BARS_W-1:0]   new_bars;
    logic                usb;

    assign o_status.first = r_first;

    assign alpha     = (r_smoothing > ALPHA_FULL) ? ALPHA_FULL : r_smoothing;
    assign alpha_inv = ALPHA_FULL - alpha;

    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_BAT_GAIN: begin
                mul_a = AVG_W'(r_bat_in);
                mul_b = r_battery_gain;
            end
            OP_MUL_VBUS_GAIN: begin
                mul_a = AVG_W'(r_vbus_in);
                mul_b = r_vbus_gain;
            end
            OP_MUL_BAT_OLD: begin
                mul_a = r_bat_avg;
                mul_b = GAIN_W'(alpha_inv);
            end
            OP_MUL_BAT_NEW: begin
                mul_a = r_bx;
                mul_b = GAIN_W'(alpha);
            end
            OP_MUL_VBUS_OLD: begin
                mul_a = r_vbus_avg;
                mul_b = GAIN_W'(alpha_inv);
            end
            OP_MUL_VBUS_NEW: begin
                mul_a = r_vx;
                mul_b = GAIN_W'(alpha);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = {{GAIN_W{1'b0}}, mul_a} * {{AVG_W{1'b0}}, mul_b};
    assign blend_sum = {1'b0, r_acc} + {1'b0, r_prod};
    assign blend_res = blend_sum[AVG_W+ALPHA_SHIFT-1:ALPHA_SHIFT];

    assign v_lo  = AVG_W'(r_min_mv) << AVG_FRAC_BITS;
    assign v_hi  = AVG_W'(r_max_mv) << AVG_FRAC_BITS;
    assign v_usb = AVG_W'(r_usb_mv) << AVG_FRAC_BITS;

    // Pick the curve segment for the smoothed battery voltage
    always_comb begin
        priority if (r_bat_avg >= V_KNEE_FULL) begin
            c_base  = PCT_W'(PCT_KNEE_FULL);
            c_slope = SLOPE_W'(SLOPE_TOP);
            c_diff  = r_bat_avg - V_KNEE_FULL;
            c_den   = v_hi - V_KNEE_FULL;
        end else if (r_bat_avg >= V_KNEE_MID) begin
            c_base  = PCT_W'(PCT_KNEE_MID);
            c_slope = SLOPE_W'(SLOPE_MID);
            c_diff  = r_bat_avg - V_KNEE_MID;
            c_den   = V_SPAN_MID;
        end else if (r_bat_avg >= V_KNEE_LOW) begin
            c_base  = PCT_W'(PCT_KNEE_LOW);
            c_slope = SLOPE_W'(SLOPE_LOW);
            c_diff  = r_bat_avg - V_KNEE_LOW;
            c_den   = V_SPAN_LOW;
        end else begin
            c_base  = '0;
            c_slope = SLOPE_W'(SLOPE_BOTTOM);
            c_diff  = r_bat_avg - v_lo;
            c_den   = V_KNEE_LOW - v_lo;
        end
    end

    assign c_num    = {{SLOPE_W{1'b0}}, c_diff} * {{AVG_W{1'b0}}, c_slope};
    assign div_take = (r_rem >= r_den);

    assign pct_sum = {1'b0, r_base} + {1'b0, r_quo};
    always_comb begin
        priority if (r_is_zero) begin
            pct = '0;
        end else if (r_is_full) begin
            pct = PCT_TOP;
        end else if (pct_sum > {1'b0, PCT_TOP}) begin
            pct = PCT_TOP;
        end else begin
            pct = pct_sum[PCT_W-1:0];
        end
    end

    assign pct_diff  = (pct > r_shown) ? (pct - r_shown) : (r_shown - pct);
    assign new_shown = (r_first || (pct_diff >= r_hyst)) ? pct : r_shown;

    always_comb begin
        priority if (new_shown == '0) begin
            new_bars = BARS_W'(0);
        end else if (new_shown >= PCT_W'(BARS_THREE_PCT)) begin
            new_bars = BARS_W'(3);
        end else if (new_shown >= PCT_W'(BARS_TWO_PCT)) begin
            new_bars = BARS_W'(2);
        end else begin
            new_bars = BARS_W'(1);
        end
    end

    assign usb = (r_vbus_avg > v_usb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_battery_gain <= RST_BATTERY_GAIN;
            r_vbus_gain    <= RST_VBUS_GAIN;
            r_smoothing    <= RST_SMOOTHING;
            r_min_mv       <= RST_MIN_MV;
            r_max_mv       <= RST_MAX_MV;
            r_hyst         <= RST_HYST;
            r_usb_mv       <= RST_USB_MV;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_BATTERY_GAIN:  r_battery_gain <= i_cfg_wdata[GAIN_W-1:0];
                CFG_VBUS_GAIN:     r_vbus_gain    <= i_cfg_wdata[GAIN_W-1:0];
                CFG_SMOOTHING:     r_smoothing    <= i_cfg_wdata[SMOOTH_W-1:0];
                CFG_MIN_MV:        r_min_mv       <= i_cfg_wdata[MIN_W-1:0];
                CFG_MAX_MV:        r_max_mv       <= i_cfg_wdata[MAX_W-1:0];
                CFG_PERCENT_HYST:  r_hyst         <= i_cfg_wdata[HYST_W-1:0];
                CFG_USB_THRESHOLD: r_usb_mv       <= i_cfg_wdata[USB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_shown    <= '0;
            r_bat_avg  <= '0;
            r_vbus_avg <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_FIRST: begin
                    r_seen     <= 1'b1;
                    r_bat_avg  <= r_bx;
                    r_vbus_avg <= r_vx;
                end
                OP_MUL_VBUS_OLD: r_bat_avg  <= blend_res;
                OP_BLEND_VBUS:   r_vbus_avg <= blend_res;
                OP_COMMIT:       r_shown    <= new_shown;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.in_take) begin
            r_bat_in  <= i_battery_mv;
            r_vbus_in <= i_vbus_mv;
            r_sw      <= i_switch_closed;
            r_first   <= !r_seen;
        end
        unique case (i_cmd.op)
            OP_MUL_VBUS_GAIN: r_bx  <= sat_scale(r_prod[PROD_SCALE_W-1:0]);
            OP_SAT_VBUS:      r_vx  <= sat_scale(r_prod[PROD_SCALE_W-1:0]);
            OP_MUL_BAT_NEW:   r_acc <= r_prod;
            OP_MUL_VBUS_NEW:  r_acc <= r_prod;
            OP_CURVE: begin
                r_rem     <= DIV_W'(c_num);
                r_den     <= DIV_W'(c_den) << (PCT_W - 1);
                r_quo     <= '0;
                r_base    <= c_base;
                r_is_zero <= (r_bat_avg <= v_lo);
                r_is_full <= (r_bat_avg >= v_hi);
            end
            OP_DIV_STEP: begin
                if (div_take) begin
                    r_rem <= r_rem - r_den;
                end
                r_quo <= {r_quo[PCT_W-2:0], div_take};
                r_den <= r_den >> 1;
            end
            OP_COMMIT: begin
                r_voltage_mv   <= r_bat_avg[AVG_W-1:AVG_FRAC_BITS];
                r_percent      <= new_shown;
                r_usb_present  <= usb;
                r_charging     <= usb && (r_bat_avg < v_hi);
                r_disconnected <= !r_sw;
                r_bars         <= new_bars;
            end
            default: ;
        endcase
    end

    assign o_voltage_mv   = r_voltage_mv;
    assign o_percent      = r_percent;
    assign o_usb_present  = r_usb_present;
    assign o_charging     = r_charging;
    assign o_disconnected = r_disconnected;
    assign o_bars         = r_bars;

endmodule

>>> hdl/battery_level_gauge.sv
// Battery level gauge: takes one input sample at a time and accepts no new one until
// the result of the last is in the output register. Each sample makes six passes
// through the shared scale/blend multiplier (only the gain scalings for the first
// sample after reset) plus a seven-step restoring divide for the percent curve.
// Reset (i_rst_n, synchronous, active low) loads default register values, clears the
// averages and shown percent, and the first sample then loads the averages directly.
module battery_level_gauge
    import blg_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS,
    parameter int AVG_FRAC_BITS  = DEF_AVG_FRAC_BITS
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ADC_W-1:0]      i_battery_mv,
    input  logic [ADC_W-1:0]      i_vbus_mv,
    input  logic                  i_switch_closed,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [MV_W-1:0]       o_voltage_mv,
    output logic [PCT_W-1:0]      o_percent,
    output logic                  o_usb_present,
    output logic                  o_charging,
    output logic                  o_disconnected,
    output logic [BARS_W-1:0]     o_bars
);

    t_dp_cmd    cmd;
    t_dp_status status;

    blg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    blg_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .AVG_FRAC_BITS  (AVG_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_battery_mv    (i_battery_mv),
        .i_vbus_mv       (i_vbus_mv),
        .i_switch_closed (i_switch_closed),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_voltage_mv    (o_voltage_mv),
        .o_percent       (o_percent),
        .o_usb_present   (o_usb_present),
        .o_charging      (o_charging),
        .o_disconnected  (o_disconnected),
        .o_bars          (o_bars)
    );

endmodule

>>> hdl/blg_checker.sv
`include "battery_level_gauge_macros.svh"

module blg_checker
    import blg_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [MV_W-1:0]   o_voltage_mv,
    input logic [PCT_W-1:0]  o_percent,
    input logic              o_usb_present,
    input logic              o_charging,
    input logic              o_disconnected,
    input logic [BARS_W-1:0] o_bars
);

    // A stalled result stays offered.
    `BLG_ASSERT_NEXT(a_valid_hold, o_out_valid && !i_out_ready, o_out_valid)

    // A stalled result keeps its payload.
    `BLG_ASSERT_NEXT(a_payload_hold, o_out_valid && !i_out_ready, $stable(o_voltage_mv) && $stable(o_percent) && $stable(o_bars) && $stable(o_usb_present) && $stable(o_charging) && $stable(o_disconnected))

    // Bar count agrees with the shown percent.
    `BLG_ASSERT_IMPL(a_bars_match, o_out_valid, (o_percent == 7'd0 && o_bars == 2'd0) || (o_percent >= 7'd67 && o_percent <= 7'd100 && o_bars == 2'd3) || (o_percent >= 7'd34 && o_percent < 7'd67 && o_bars == 2'd2) || (o_percent != 7'd0 && o_percent < 7'd34 && o_bars == 2'd1))

    // Charging needs USB power.
    `BLG_ASSERT_IMPL(a_charge_usb, o_out_valid && o_charging, o_usb_present)

endmodule

bind battery_level_gauge blg_checker u_blg_checker (.*);
